FILE: hw/rtl/ptw_pkg.sv
// ptw_pkg: shared types, field widths and codes for the four-level page table walker
// no dependencies; imported by ptw_step, four_level_page_table_walker_core and the testbench
package ptw_pkg;

    localparam int PHYS_BITS = 52;

    localparam int VA_W    = 48;
    localparam int ROOT_W  = 52;
    localparam int ENTRY_W = 64;
    localparam int RADDR_W = 52;
    localparam int RES_W   = 64;
    localparam int LEVEL_W = 3;
    localparam int FLAGS_W = 12;

    // stream payload widths, padded to whole bytes
    localparam int IN_BITS  = VA_W + ROOT_W + ENTRY_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = RADDR_W + 1 + RES_W + LEVEL_W + FLAGS_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // input selector codes
    localparam logic MODE_START  = 1'b0;
    localparam logic MODE_RETURN = 1'b1;

    // result kind codes
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // walk status codes
    localparam logic STATUS_OK          = 1'b0;
    localparam logic STATUS_NOT_PRESENT = 1'b1;

    // table whose entry is awaited
    localparam logic [1:0] TBL_PT   = 2'd0;
    localparam logic [1:0] TBL_PD   = 2'd1;
    localparam logic [1:0] TBL_PDP  = 2'd2;
    localparam logic [1:0] TBL_PML4 = 2'd3;

    localparam logic [LEVEL_W-1:0] LEVEL_FRAME = 3'd0;

    localparam int BIT_PRESENT   = 0;
    localparam int BIT_PAGE_SIZE = 7;

    typedef struct packed {
        logic               busy;
        logic [1:0]         level;
        logic [VA_W-1:0]    vaddr;
        logic [ENTRY_W-1:0] prev;
    } t_walk_state;

    typedef struct packed {
        logic               mode;
        logic [VA_W-1:0]    virt_addr;
        logic [ROOT_W-1:0]  table_root;
        logic [ENTRY_W-1:0] read_data;
    } t_item;

    typedef struct packed {
        logic               kind;
        logic [RADDR_W-1:0] read_address;
        logic               status;
        logic [RES_W-1:0]   result_addr;
        logic [LEVEL_W-1:0] level;
        logic [FLAGS_W-1:0] page_flags;
    } t_result;

    // byte address of the entry for one table: base frame, nine index bits, 8-byte entries
    function automatic logic [RADDR_W-1:0] entry_addr(input logic [ENTRY_W-1:0] base,
                                                      input logic [VA_W-1:0]    va,
                                                      input logic [1:0]         tbl);
        logic [8:0]           idx;
        logic [PHYS_BITS-1:0] addr;
        case (tbl)
            TBL_PT:   idx = va[20:12];
            TBL_PD:   idx = va[29:21];
            TBL_PDP:  idx = va[38:30];
            TBL_PML4: idx = va[47:39];
            default:  idx = va[47:39];
        endcase
        addr = {base[PHYS_BITS-1:12], idx, 3'b000};
        return RADDR_W'(addr);
    endfunction

endpackage

FILE: hw/rtl/four_level_page_table_walker_core.sv
// four_level_page_table_walker_core: x86-64 four-level page walker, one item per cycle unless the result side stalls
// registered path from input transfer to result transfer: input register, then result register
// throughput: one item per cycle while the result side is not stalled, set by the single pass through ptw_step
// a memory return while no walk is active gives no result
// reset: synchronous active-low i_rst_n clears the walk state, both stages and the 1 GiB enable
// depends on ptw_pkg and ptw_step
module four_level_page_table_walker_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_data,     // huge_1g_enable

    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [ptw_pkg::IN_W-1:0]  s_axis_tdata,   // virt_addr, table_root, read_data, pad
    input  logic                      s_axis_tuser,   // mode

    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [ptw_pkg::OUT_W-1:0] m_axis_tdata,   // read_address, status, result_addr,
                                                      // level, page_flags, pad
    output logic                      m_axis_tuser    // kind
);
    import ptw_pkg::*;

    logic        r_huge_1g;
    logic        r_in_valid;
    t_item       r_in;
    t_walk_state r_state;
    logic        r_out_valid;
    t_result     r_out;

    t_walk_state n_state;
    t_result     n_out;
    logic        n_res_valid;
    logic        adv;

    ptw_step u_step (
        .i_state          (r_state),
        .i_item           (r_in),
        .i_huge_1g_enable (r_huge_1g),
        .o_state          (n_state),
        .o_res_valid      (n_res_valid),
        .o_res            (n_out)
    );

    // input stage moves on when the result register is free or drains this cycle
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_huge_1g <= 1'b0;
        end else if (i_cfg_valid) begin
            r_huge_1g <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.mode       <= s_axis_tuser;
            r_in.virt_addr  <= s_axis_tdata[VA_W-1:0];
            r_in.table_root <= s_axis_tdata[VA_W+ROOT_W-1:VA_W];
            r_in.read_data  <= s_axis_tdata[IN_BITS-1:VA_W+ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= n_res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = OUT_W'({r_out.page_flags, r_out.level, r_out.result_addr,
                                   r_out.status, r_out.read_address});

`ifndef SYNTHESIS
    a_read_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_READ |-> r_out.read_address[2:0] == 3'b000)
        else $error("read request address not entry aligned");

    a_ok_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_DONE && r_out.status == STATUS_OK
        |-> r_out.level == LEVEL_FRAME && r_out.read_address == '0)
        else $error("translated result with nonzero level or read address");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && n_res_valid && n_out.kind == KIND_READ |=> r_state.busy)
        else $error("read request issued without an active walk");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && n_res_valid && n_out.kind == KIND_DONE |=> !r_state.busy)
        else $error("walk still active after finishing");
`endif

endmodule

FILE: hw/rtl/ptw_step.sv
// ptw_step: one walk step, decides the next walk state and the result for one item
// depends on ptw_pkg
module ptw_step (
    input  ptw_pkg::t_walk_state i_state,
    input  ptw_pkg::t_item       i_item,
    input  logic                 i_huge_1g_enable,
    output ptw_pkg::t_walk_state o_state,
    output logic                 o_res_valid,
    output ptw_pkg::t_result     o_res
);
    import ptw_pkg::*;

    logic [ENTRY_W-1:0] entry;
    logic               present;
    logic               leaf_bit;

    assign entry    = i_item.read_data;
    assign present  = entry[BIT_PRESENT];
    assign leaf_bit = entry[BIT_PAGE_SIZE];

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_item.mode == MODE_START) begin
            // a start always wins, even over a walk in flight
            o_state.busy  = 1'b1;
            o_state.level = TBL_PML4;
            o_state.vaddr = i_item.virt_addr;
            o_state.prev  = ENTRY_W'(i_item.table_root);
            o_res_valid   = 1'b1;
            o_res.kind    = KIND_READ;
            o_res.read_address = entry_addr(ENTRY_W'(i_item.table_root),
                                            i_item.virt_addr, TBL_PML4);
        end else if (i_state.busy) begin
            o_res_valid = 1'b1;
            if (!present) begin
                o_state.busy      = 1'b0;
                o_res.kind        = KIND_DONE;
                o_res.status      = STATUS_NOT_PRESENT;
                o_res.result_addr = i_state.prev;
                o_res.level       = LEVEL_W'(i_state.level) + LEVEL_W'(1);
            end else if (i_state.level == TBL_PDP && leaf_bit && i_huge_1g_enable) begin
                o_state.busy      = 1'b0;
                o_res.kind        = KIND_DONE;
                o_res.status      = STATUS_OK;
                o_res.result_addr = RES_W'({entry[PHYS_BITS-1:30], i_state.vaddr[29:0]});
                o_res.level       = LEVEL_FRAME;
            end else if (i_state.level == TBL_PD && leaf_bit) begin
                o_state.busy      = 1'b0;
                o_res.kind        = KIND_DONE;
                o_res.status      = STATUS_OK;
                o_res.result_addr = RES_W'({entry[PHYS_BITS-1:21], i_state.vaddr[20:0]});
                o_res.level       = LEVEL_FRAME;
            end else if (i_state.level == TBL_PT) begin
                o_state.busy      = 1'b0;
                o_res.kind        = KIND_DONE;
                o_res.status      = STATUS_OK;
                o_res.result_addr = RES_W'({entry[PHYS_BITS-1:12], i_state.vaddr[11:0]});
                o_res.level       = LEVEL_FRAME;
                o_res.page_flags  = entry[FLAGS_W-1:0];
            end else begin
                // table pointer, go one level down
                o_state.prev  = entry;
                o_state.level = i_state.level - 2'd1;
                o_res.kind    = KIND_READ;
                o_res.read_address = entry_addr(entry, i_state.vaddr,
                                                i_state.level - 2'd1);
            end
        end
    end

endmodule

FILE: verif/tb_four_level_page_table_walker_core.sv
// testbench for four_level_page_table_walker_core: directed walks, then random walks
// checked against an in-bench model of the walker; depends on ptw_pkg and the core rtl
`timescale 1ns / 100ps

module tb_four_level_page_table_walker_core;
    import ptw_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 6;
    localparam int PER_PHASE    = 320;

    // result payload offsets, lowest field first
    localparam int O_STATUS = RADDR_W;
    localparam int O_RES    = O_STATUS + 1;
    localparam int O_LEVEL  = O_RES + RES_W;
    localparam int O_FLAGS  = O_LEVEL + LEVEL_W;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tuser;

    logic              in_fire;
    logic              cfg_fire;
    bit                calm_stretch;
    bit                hold_request;
    int unsigned       walk_count;
    int unsigned       cycle_count;
    t_item             mon_item;
    t_result           mon_result;

    four_level_page_table_walker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    class page_walk_checker;
        t_result            outcome_q[$];
        bit                 huge_1g_on;
        bit                 walking;
        logic [1:0]         awaited_tbl;
        logic [VA_W-1:0]    walk_vaddr;
        logic [ENTRY_W-1:0] last_entry;
        int unsigned        mismatches;
        int unsigned        outcomes_made;

        function int pending();
            return outcome_q.size();
        endfunction

        function bit walk_active();
            return walking;
        endfunction

        function void set_huge_1g(input bit v);
            huge_1g_on = v;
        endfunction

        // entry slot in the table now awaited: frame of base, nine va bits, 8-byte entries
        function logic [RADDR_W-1:0] slot_address(input logic [ENTRY_W-1:0] base);
            logic [8:0] idx;
            idx = 9'(walk_vaddr >> (12 + 9 * int'(awaited_tbl)));
            return RADDR_W'({base[PHYS_BITS-1:12], idx, 3'b000});
        endfunction

        function void push_outcome(input logic kind, input logic [RADDR_W-1:0] raddr,
                                   input logic status, input logic [RES_W-1:0] addr,
                                   input logic [LEVEL_W-1:0] lvl,
                                   input logic [FLAGS_W-1:0] flags);
            t_result r;
            r.kind         = kind;
            r.read_address = raddr;
            r.status       = status;
            r.result_addr  = addr;
            r.level        = lvl;
            r.page_flags   = flags;
            outcome_q.push_back(r);
            outcomes_made++;
            if (kind == KIND_DONE) begin
                walking = 1'b0;
            end
        endfunction

        function void note_accepted(input t_item it);
            logic [ENTRY_W-1:0] e;
            e = it.read_data;
            if (it.mode == MODE_START) begin
                // a start always wins, even over a walk in flight
                walk_vaddr  = it.virt_addr;
                last_entry  = ENTRY_W'(it.table_root);
                awaited_tbl = TBL_PML4;
                walking     = 1'b1;
                push_outcome(KIND_READ, slot_address(last_entry), STATUS_OK, '0, '0, '0);
            end else if (walking) begin
                if (!e[BIT_PRESENT]) begin
                    push_outcome(KIND_DONE, '0, STATUS_NOT_PRESENT, last_entry,
                                 {1'b0, awaited_tbl} + 3'd1, '0);
                end else if (awaited_tbl == TBL_PDP && e[BIT_PAGE_SIZE] && huge_1g_on) begin
                    push_outcome(KIND_DONE, '0, STATUS_OK,
                                 (RES_W'(e[PHYS_BITS-1:30]) << 30) | RES_W'(walk_vaddr[29:0]),
                                 LEVEL_FRAME, '0);
                end else if (awaited_tbl == TBL_PD && e[BIT_PAGE_SIZE]) begin
                    push_outcome(KIND_DONE, '0, STATUS_OK,
                                 (RES_W'(e[PHYS_BITS-1:21]) << 21) | RES_W'(walk_vaddr[20:0]),
                                 LEVEL_FRAME, '0);
                end else if (awaited_tbl == TBL_PT) begin
                    push_outcome(KIND_DONE, '0, STATUS_OK,
                                 (RES_W'(e[PHYS_BITS-1:12]) << 12) | RES_W'(walk_vaddr[11:0]),
                                 LEVEL_FRAME, e[FLAGS_W-1:0]);
                end else begin
                    last_entry  = e;
                    awaited_tbl = awaited_tbl - 2'd1;
                    push_outcome(KIND_READ, slot_address(e), STATUS_OK, '0, '0, '0);
                end
            end
        endfunction

        task report(input string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task compare_field(input string name, input logic [63:0] got,
                           input logic [63:0] want);
            if (got !== want) begin
                report($sformatf("%s got %h expected %h", name, got, want));
            end
        endtask

        task check_outcome(input t_result got);
            t_result want;
            if (outcome_q.size() == 0) begin
                report($sformatf("result transfer with nothing pending, kind %0h", got.kind));
            end else begin
                want = outcome_q.pop_front();
                compare_field("kind", 64'(got.kind), 64'(want.kind));
                compare_field("read_address", 64'(got.read_address), 64'(want.read_address));
                compare_field("status", 64'(got.status), 64'(want.status));
                compare_field("result_addr", got.result_addr, want.result_addr);
                compare_field("level", 64'(got.level), 64'(want.level));
                compare_field("page_flags", 64'(got.page_flags), 64'(want.page_flags));
            end
        endtask
    endclass

    page_walk_checker walk_chk = new();

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // transfers are taken at the rising edge, before the core's registers move
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                walk_chk.set_huge_1g(i_cfg_data);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                mon_item.mode       = s_axis_tuser;
                mon_item.virt_addr  = s_axis_tdata[0 +: VA_W];
                mon_item.table_root = s_axis_tdata[VA_W +: ROOT_W];
                mon_item.read_data  = s_axis_tdata[VA_W + ROOT_W +: ENTRY_W];
                walk_chk.note_accepted(mon_item);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                mon_result.kind         = m_axis_tuser;
                mon_result.read_address = m_axis_tdata[0 +: RADDR_W];
                mon_result.status       = m_axis_tdata[O_STATUS];
                mon_result.result_addr  = m_axis_tdata[O_RES +: RES_W];
                mon_result.level        = m_axis_tdata[O_LEVEL +: LEVEL_W];
                mon_result.page_flags   = m_axis_tdata[O_FLAGS +: FLAGS_W];
                walk_chk.check_outcome(mon_result);
            end
        end
        in_fire  <= s_axis_tvalid && s_axis_tready;
        cfg_fire <= i_cfg_valid && o_cfg_ready;
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                m_axis_tready = 1'b0;
                hold_request  = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = calm_stretch || ($urandom_range(99) >= 26);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random present entry with the page-size bit as asked
    function automatic logic [63:0] rand_pte(input bit leaf);
        logic [63:0] e;
        e                = rand64();
        e[BIT_PRESENT]   = 1'b1;
        e[BIT_PAGE_SIZE] = leaf;
        return e;
    endfunction

    // called and returns at a falling edge; valid stays up into the next item
    task automatic send_item(input logic mode, input logic [63:0] va,
                             input logic [63:0] root, input logic [63:0] data);
        while (!calm_stretch && $urandom_range(99) < 26) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tuser  = mode;
        s_axis_tdata  = IN_W'({data, root[ROOT_W-1:0], va[VA_W-1:0]});
        s_axis_tvalid = 1'b1;
        do @(negedge i_clk); while (!in_fire);
    endtask

    task automatic write_huge_1g(input bit v);
        s_axis_tvalid = 1'b0;
        while (walk_chk.pending() != 0) @(negedge i_clk);
        // a return that was ignored may still be in the pipe
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_data  = v;
        i_cfg_valid = 1'b1;
        do @(negedge i_clk); while (!cfg_fire);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_walk();
        int unsigned roll;
        int unsigned depth;
        int unsigned k;
        logic [63:0] e;
        roll = $urandom_range(99);
        if (roll < 5) begin
            // stray return, may land on an abandoned walk or on an idle walker
            send_item(MODE_RETURN, rand64(), rand64(), rand64());
        end else begin
            send_item(MODE_START, rand64(), rand64(), rand64());
            depth = (roll < 13) ? $urandom_range(0, 3) : 4;
            k = 0;
            while (k < depth && walk_chk.walk_active()) begin
                e = rand_pte($urandom_range(99) < 30);
                e[BIT_PRESENT] = ($urandom_range(99) >= 8);
                send_item(MODE_RETURN, rand64(), rand64(), e);
                k++;
            end
            if ($urandom_range(99) < 4) begin
                send_item(MODE_RETURN, rand64(), rand64(), rand64());
            end
        end
    endtask

    initial begin
        int unsigned target;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_START;
        calm_stretch  = 1'b0;
        hold_request  = 1'b0;
        walk_count    = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        write_huge_1g(1'b0);
        // return with no walk running is dropped
        send_item(MODE_RETURN, '1, '1, '1);
        // all-ones address, unaligned root, missing pml4 entry
        send_item(MODE_START, '1, '1, '0);
        send_item(MODE_RETURN, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE);
        // page-size bit ignored at pml4, at pdp while 1g is off, and at pt
        send_item(MODE_START, '0, '0, '1);
        send_item(MODE_RETURN, '1, '1, '1);
        send_item(MODE_RETURN, '1, '1, '1);
        send_item(MODE_RETURN, '1, '1, ~64'h80);
        send_item(MODE_RETURN, '1, '1, '1);
        // minimal present entries, then missing pd entry
        send_item(MODE_START, rand64(), rand64(), '0);
        send_item(MODE_RETURN, '0, '0, 64'h1);
        send_item(MODE_RETURN, '0, '0, 64'h1);
        send_item(MODE_RETURN, '0, '0, '0);

        write_huge_1g(1'b1);
        send_item(MODE_START, rand64(), rand64(), rand64());
        send_item(MODE_RETURN, rand64(), rand64(), '1);
        send_item(MODE_RETURN, rand64(), rand64(), '1);
        send_item(MODE_START, rand64(), rand64(), rand64());
        send_item(MODE_RETURN, rand64(), rand64(), rand_pte(1'b0));
        send_item(MODE_RETURN, rand64(), rand64(), rand_pte(1'b0));
        send_item(MODE_RETURN, rand64(), rand64(), rand_pte(1'b1));
        // restart in the middle of a walk, then a missing pt entry
        send_item(MODE_START, rand64(), rand64(), rand64());
        send_item(MODE_RETURN, rand64(), rand64(), rand_pte(1'b0));
        send_item(MODE_START, rand64(), rand64(), rand64());
        send_item(MODE_RETURN, rand64(), rand64(), rand_pte(1'b1));
        send_item(MODE_RETURN, rand64(), rand64(), rand_pte(1'b0));
        send_item(MODE_RETURN, rand64(), rand64(), rand_pte(1'b0));
        send_item(MODE_RETURN, rand64(), rand64(), 64'h0);

        for (int phase = 0; phase < PHASES; phase++) begin
            write_huge_1g(phase[0]);
            target = walk_chk.outcomes_made + PER_PHASE;
            while (walk_chk.outcomes_made < target) begin
                if (walk_count == 150) begin
                    hold_request = 1'b1;
                end
                calm_stretch = (walk_count >= 400 && walk_count < 520);
                random_walk();
                walk_count++;
            end
        end

        s_axis_tvalid = 1'b0;
        while (walk_chk.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES * 2) @(negedge i_clk);
        if (walk_chk.mismatches == 0 && walk_chk.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: four_level_page_table_walker_core.f
hw/rtl/ptw_pkg.sv
hw/rtl/ptw_step.sv
hw/rtl/four_level_page_table_walker_core.sv
verif/tb_four_level_page_table_walker_core.sv
